@@ sv/cave_automaton_step_unit_defines.svh @@
// Assertion macros for the cave automaton step unit.
// Used by the top level; expects clk and arst_n in the enclosing scope.
`ifndef CAVE_AUTOMATON_STEP_UNIT_DEFINES_SVH
`define CAVE_AUTOMATON_STEP_UNIT_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define CAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cave automaton step unit: same-cycle check failed");

// next-cycle implication, held off while reset is asserted
`define CAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cave automaton step unit: next-cycle check failed");

`endif

@@ sv/cas_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register codes and control structs of the cave automaton step unit.
// No dependencies.
package cas_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int HGT_W      = 16;
	localparam int ROW_W      = 16;
	localparam int LIM_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [WID_W-1:0] WIDTH_RST   = WID_W'(64);
	localparam logic [HGT_W-1:0] HEIGHT_RST  = HGT_W'(64);
	localparam logic [LIM_W-1:0] SURVIVE_RST = LIM_W'(4);
	localparam logic [LIM_W-1:0] BIRTH_RST   = LIM_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_SURVIVE_LIMIT = 2'd2,
		REG_BIRTH_LIMIT   = 2'd3
	} cfg_reg_t;

	// which neighbor rows / columns fall outside the frame
	typedef struct packed {
		logic top;
		logic mid_r;
		logic bot;
		logic left;
		logic mid_c;
		logic right;
	} border_t;

	// position info for one accepted item
	typedef struct packed {
		logic [COL_W-1:0] addr;
		logic             emit;
		logic             last;
		logic [COL_W-1:0] out_col;
		logic [ROW_W-1:0] out_row;
		border_t          border;
	} pos_t;

	// one line buffer entry: cell two rows up and one row up
	typedef struct packed {
		logic above;
		logic middle;
	} line_word_t;

endpackage

@@ sv/cas_cell_if.sv @@
`timescale 1ns / 1ps
// Input channel of the cave automaton step unit: one cell per transaction.
// Depends on nothing.
interface cas_cell_if;
	logic valid;
	logic ready;
	logic cell_req;
	logic filler;

	modport source (output valid, output cell_req, output filler, input ready);
	modport sink (input valid, input cell_req, input filler, output ready);
endinterface

@@ sv/cas_result_if.sv @@
`timescale 1ns / 1ps
// Result channel of the cave automaton step unit: one next-generation cell per transaction.
// Depends on cas_pkg.
interface cas_result_if;
	logic                       valid;
	logic                       ready;
	logic                       new_cell;
	logic [cas_pkg::COL_W-1:0]  col;
	logic [cas_pkg::ROW_W-1:0]  row;
	logic                       frame_end;

	modport source (output valid, output new_cell, output col, output row, output frame_end,
		input ready);
	modport sink (input valid, input new_cell, input col, input row, input frame_end,
		output ready);
endinterface

@@ sv/cave_automaton_step_unit.sv @@
`timescale 1ns / 1ps
// Cave automaton step unit: one generation of a cave-forming cellular automaton.
// Depends on cas_pkg, cas_cell_if, cas_result_if, cas_line_ram, cas_pos_ctrl,
// cas_window_eval and the assertion macros.
//
// Usage:
//  - cells (sink): one cell per transaction in row-major order, cell_req 1 = rock.
//    After the frame's last cell the sender appends frame_width+1 filler transactions
//    (filler = 1) to drain the pipeline. Another generation = stream the result back in.
//  - results (source): one transaction per cell with new_cell, col, row; frame_end
//    marks the frame's last cell. Counters return to frame start after it.
//  - cfg_we / cfg_index / cfg_wdata: register writes, taken at any clock edge with
//    cfg_we high. Write only while the block is idle between frames.
//  - Ordering: a cell's result is produced by the transaction frame_width+1 items
//    later; it passes stage 1, then its result is held in the output register.
//  - Throughput: one cell per cycle while no held result stalls stage 1, bounded by
//    the line buffer's one read (at acceptance) and one write-back (stage 1) per cell.
//  - Reset: position counters and window clear, registers take 64 x 64, limits 4/4.
//    The line buffer is not cleared; off-frame reads are masked by the border logic.
//  - Stall: a waiting result blocks the working stage only if that stage holds
//    another result; cells that produce nothing still move through.
`include "cave_automaton_step_unit_defines.svh"

module cave_automaton_step_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	cas_cell_if.sink                       cells,
	cas_result_if.source                   results,
	input  logic                           cfg_we,
	input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [cas_pkg::WID_W-1:0] frame_width_q;
	logic [cas_pkg::HGT_W-1:0] frame_height_q;
	logic [cas_pkg::LIM_W-1:0] survive_limit_q;
	logic [cas_pkg::LIM_W-1:0] birth_limit_q;
	logic [cas_pkg::WID_W-1:0] w_eff;
	logic [cas_pkg::HGT_W-1:0] h_eff;

	// handshake
	logic accept;
	logic out_free;
	logic s1_adv;
	logic cell_in;

	// position of the incoming cell
	cas_pkg::pos_t cur_pos;

	// working stage: memory read data arrives here
	logic                valid_s1;
	logic                cell_s1;
	cas_pkg::pos_t       pos_s1;
	logic                fwd_s1;
	logic                fwd_above_s1;
	logic                fwd_mid_s1;
	cas_pkg::line_word_t ram_rd;
	cas_pkg::line_word_t ram_wr;
	logic                above_eff;
	logic                mid_eff;
	logic                new_cell;

	// output register
	logic                      res_valid_q;
	logic                      res_new_cell_q;
	logic [cas_pkg::COL_W-1:0] res_col_q;
	logic [cas_pkg::ROW_W-1:0] res_row_q;
	logic                      res_last_q;

	//--------------------------------------------------------------------
	// Configuration
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= cas_pkg::WIDTH_RST;
			frame_height_q  <= cas_pkg::HEIGHT_RST;
			survive_limit_q <= cas_pkg::SURVIVE_RST;
			birth_limit_q   <= cas_pkg::BIRTH_RST;
		end else if (cfg_we) begin
			case (cas_pkg::cfg_reg_t'(cfg_index))
				cas_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_wdata[cas_pkg::WID_W-1:0];
				end
				cas_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_wdata[cas_pkg::HGT_W-1:0];
				end
				cas_pkg::REG_SURVIVE_LIMIT: begin
					survive_limit_q <= cfg_wdata[cas_pkg::LIM_W-1:0];
				end
				cas_pkg::REG_BIRTH_LIMIT: begin
					birth_limit_q <= cfg_wdata[cas_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// width 0 acts as 1, width above the line buffer is clipped; height 0 acts as 1
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = cas_pkg::WID_W'(1);
		end else if (frame_width_q > cas_pkg::WID_W'(cas_pkg::MAX_WIDTH)) begin
			w_eff = cas_pkg::WID_W'(cas_pkg::MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		h_eff = (frame_height_q == '0) ? cas_pkg::HGT_W'(1) : frame_height_q;
	end

	//--------------------------------------------------------------------
	// Handshake: stage 1 only waits when it carries a result and the
	// output register is still held by the receiver.
	//--------------------------------------------------------------------
	assign out_free    = !res_valid_q || results.ready;
	assign s1_adv      = valid_s1 && (!pos_s1.emit || out_free);
	assign cells.ready = !valid_s1 || s1_adv;
	assign accept      = cells.valid && cells.ready;
	assign cell_in     = cells.filler ? 1'b0 : cells.cell_req;

	cas_pos_ctrl u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.cur     (cur_pos)
	);

	//--------------------------------------------------------------------
	// Line buffer: read at acceptance, write back from stage 1.
	// Entry per column = {cell two rows up, cell one row up}.
	//--------------------------------------------------------------------
	assign ram_wr.above  = mid_eff;
	assign ram_wr.middle = cell_s1;

	cas_line_ram u_ram (
		.clk   (clk),
		.re    (accept),
		.raddr (cur_pos.addr),
		.rdata (ram_rd),
		.we    (s1_adv),
		.waddr (pos_s1.addr),
		.wdata (ram_wr)
	);

	//--------------------------------------------------------------------
	// Stage 1
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// A read of the column being written back in the same cycle (one-column
	// frames) sees stale data, so the write-back values are forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1      <= cell_in;
			pos_s1       <= cur_pos;
			fwd_s1       <= valid_s1 && (pos_s1.addr == cur_pos.addr);
			fwd_above_s1 <= mid_eff;
			fwd_mid_s1   <= cell_s1;
		end
	end

	assign above_eff = fwd_s1 ? fwd_above_s1 : ram_rd.above;
	assign mid_eff   = fwd_s1 ? fwd_mid_s1 : ram_rd.middle;

	cas_window_eval u_win (
		.clk           (clk),
		.arst_n        (arst_n),
		.shift         (s1_adv),
		.col_new       ({above_eff, mid_eff, cell_s1}),
		.border        (pos_s1.border),
		.survive_limit (survive_limit_q),
		.birth_limit   (birth_limit_q),
		.new_cell      (new_cell)
	);

	//--------------------------------------------------------------------
	// Output register
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && pos_s1.emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.emit) begin
			res_new_cell_q <= new_cell;
			res_col_q      <= pos_s1.out_col;
			res_row_q      <= pos_s1.out_row;
			res_last_q     <= pos_s1.last;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.new_cell  = res_new_cell_q;
	assign results.col       = res_col_q;
	assign results.row       = res_row_q;
	assign results.frame_end = res_last_q;

	//--------------------------------------------------------------------
	// Checks
	//--------------------------------------------------------------------
	// stage 1 holds only behind a result the receiver has not taken
	`CAS_ASSERT_NOW(a_s1_stall_cause, valid_s1 && !s1_adv, res_valid_q && !results.ready)
	// after the frame's last cell the next item starts a fresh frame
	`CAS_ASSERT_NEXT(a_frame_restart, accept && cur_pos.emit && cur_pos.last, !cur_pos.emit)
	// a new result always comes from stage 1 carrying one
	`CAS_ASSERT_NOW(a_result_source, $rose(res_valid_q), $past(s1_adv && pos_s1.emit))

endmodule

@@ sv/cas_line_ram.sv @@
`timescale 1ns / 1ps
// Line buffer memory: one entry per column, holding the two previous rows.
// Depends on cas_pkg. One write and one registered read per cycle.
module cas_line_ram (
	input  logic                      clk,
	input  logic                      re,
	input  logic [cas_pkg::COL_W-1:0] raddr,
	output cas_pkg::line_word_t       rdata,
	input  logic                      we,
	input  logic [cas_pkg::COL_W-1:0] waddr,
	input  cas_pkg::line_word_t       wdata
);

	cas_pkg::line_word_t mem [cas_pkg::MAX_WIDTH];
	cas_pkg::line_word_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-during-write returns the old entry
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ sv/cas_pos_ctrl.sv @@
`timescale 1ns / 1ps
// Stream position tracking: input column/row, result column/row, frame end and border flags.
// Depends on cas_pkg.
module cas_pos_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [cas_pkg::WID_W-1:0] w_eff,
	input  logic [cas_pkg::HGT_W-1:0] h_eff,
	output cas_pkg::pos_t             cur
);

	localparam logic [1:0] IN_ROW_SAT = 2'd2;

	logic [cas_pkg::COL_W-1:0] in_col_q;
	logic [1:0]                in_row_q;   // saturates: only rows 0, 1 and later matter
	logic [cas_pkg::COL_W-1:0] out_col_q;
	logic [cas_pkg::ROW_W-1:0] out_row_q;

	logic [cas_pkg::WID_W-1:0] in_col_nx;
	logic [cas_pkg::WID_W-1:0] out_col_nx;
	logic [cas_pkg::ROW_W:0]   out_row_nx;
	logic [cas_pkg::ROW_W:0]   h_ext;
	logic [cas_pkg::WID_W:0]   w_plus1;
	logic                      in_wrap;
	logic                      out_wrap;

	always_comb begin
		in_col_nx  = {1'b0, in_col_q} + cas_pkg::WID_W'(1);
		out_col_nx = {1'b0, out_col_q} + cas_pkg::WID_W'(1);
		out_row_nx = {1'b0, out_row_q} + (cas_pkg::ROW_W+1)'(1);
		h_ext      = {1'b0, h_eff};
		w_plus1    = {1'b0, w_eff} + (cas_pkg::WID_W+1)'(1);
		in_wrap    = in_col_nx >= w_eff;
		out_wrap   = out_col_nx >= w_eff;

		cur.addr = in_col_q;
		// stream position >= width + 1: a full window is present
		cur.emit = in_row_q[1]
			|| (in_row_q == 2'd1 && in_col_q != '0)
			|| ({2'b0, in_col_q} >= w_plus1);
		cur.last    = (out_row_nx >= h_ext) && out_wrap;
		cur.out_col = out_col_q;
		cur.out_row = out_row_q;

		cur.border.top   = (out_row_q == '0) || ({1'b0, out_row_q} >= h_ext + (cas_pkg::ROW_W+1)'(1));
		cur.border.mid_r = {1'b0, out_row_q} >= h_ext;
		cur.border.bot   = out_row_nx >= h_ext;
		cur.border.left  = (out_col_q == '0) || ({2'b0, out_col_q} >= w_plus1);
		cur.border.mid_c = {1'b0, out_col_q} >= w_eff;
		cur.border.right = out_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (advance) begin
			if (cur.emit && cur.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : in_col_nx[cas_pkg::COL_W-1:0];
				if (in_wrap && in_row_q != IN_ROW_SAT) begin
					in_row_q <= in_row_q + 2'd1;
				end
				if (cur.emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						if (out_row_q != '1) begin
							out_row_q <= out_row_nx[cas_pkg::ROW_W-1:0];
						end
					end else begin
						out_col_q <= out_col_nx[cas_pkg::COL_W-1:0];
					end
				end
			end
		end
	end

endmodule

@@ sv/cas_window_eval.sv @@
`timescale 1ns / 1ps
// 3x3 neighborhood window and the birth / survive rule.
// Depends on cas_pkg. Window is two stored column triples plus the incoming one.
module cas_window_eval (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic [2:0]                col_new,   // {top, mid, bot}
	input  cas_pkg::border_t          border,
	input  logic [cas_pkg::LIM_W-1:0] survive_limit,
	input  logic [cas_pkg::LIM_W-1:0] birth_limit,
	output logic                      new_cell
);

	logic [2:0]                col_l_q;
	logic [2:0]                col_c_q;
	logic [7:0]                nb;
	logic [cas_pkg::CNT_W-1:0] live_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_l_q <= '0;
			col_c_q <= '0;
		end else if (shift) begin
			col_l_q <= col_c_q;
			col_c_q <= col_new;
		end
	end

	// off-frame neighbors count as live
	always_comb begin
		nb[0] = col_l_q[2] | border.top   | border.left;
		nb[1] = col_l_q[1] | border.mid_r | border.left;
		nb[2] = col_l_q[0] | border.bot   | border.left;
		nb[3] = col_c_q[2] | border.top   | border.mid_c;
		nb[4] = col_c_q[0] | border.bot   | border.mid_c;
		nb[5] = col_new[2] | border.top   | border.right;
		nb[6] = col_new[1] | border.mid_r | border.right;
		nb[7] = col_new[0] | border.bot   | border.right;

		live_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			live_cnt = live_cnt + cas_pkg::CNT_W'(nb[i]);
		end

		new_cell = col_c_q[1] ? (live_cnt >= survive_limit) : (live_cnt > birth_limit);
	end

endmodule

@@ tb/cave_automaton_step_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cave_automaton_step_unit: streams frames of cells, predicts each
// next-generation cell in a local line history and compares every result transaction.
// Depends on cas_pkg, cas_cell_if, cas_result_if and the step unit RTL.
module cave_automaton_step_unit_tb;

	// Line history: two full rows plus the 3x3 window slack, in stream order.
	localparam int unsigned HIST_LEN = 2 * cas_pkg::MAX_WIDTH + 4;
	localparam int          DRAIN_GAP = 12;  // cycles after the last result before a reg write

	typedef struct packed {
		logic                      new_cell;
		logic [cas_pkg::COL_W-1:0] col;
		logic [cas_pkg::ROW_W-1:0] row;
		logic                      frame_end;
	} cave_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata;

	cas_cell_if   cells_if ();
	cas_result_if results_if ();

	cave_automaton_step_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cells     (cells_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Local copy of the register file, as the block sees it.
	logic [cas_pkg::WID_W-1:0] cfg_width;
	logic [cas_pkg::HGT_W-1:0] cfg_height;
	logic [cas_pkg::LIM_W-1:0] cfg_survive;
	logic [cas_pkg::LIM_W-1:0] cfg_birth;

	// Predictor state: cell history, write pointer, feed and emit positions.
	bit          hist_cells [HIST_LEN];
	int unsigned hist_wr;
	int unsigned feed_col, feed_row;
	int unsigned emit_col, emit_row;

	cave_result_t next_gen_q [$];  // predicted results, oldest first
	int           fail_count;
	int           send_idle_pct;   // chance the sender holds off before a transaction
	int           stall_pct;       // chance the receiver drops ready in a cycle

	// ------------------------------------------------------------------
	// Clock, receiver backpressure
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: far above the slowest legal run (~2k transactions, both sides idling).
	initial begin
		#20_000_000;
		$display("cave_automaton_step_unit_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Out-of-range sizes are clamped the way the block does it.
	function automatic int unsigned eff_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > cas_pkg::MAX_WIDTH)
			return cas_pkg::MAX_WIDTH;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	// One accepted cell transaction. The cell answered is the one width+1 items back;
	// the first width+1 items of a frame produce nothing.
	function automatic void predict_next_gen(input bit cell_in, input bit drain);
		int unsigned  w, h, pos, center, idx;
		int           rr, cc, dr, dc, off;
		int unsigned  live_nb;
		bit           cur, nxt, last;
		cave_result_t r;
		w = eff_width();
		h = eff_height();
		pos = feed_row * w + feed_col;
		hist_cells[hist_wr] = drain ? 1'b0 : cell_in;
		if (pos >= w + 1) begin
			center = (hist_wr + HIST_LEN - (w + 1)) % HIST_LEN;
			cur = hist_cells[center];
			live_nb = 0;
			for (dr = -1; dr <= 1; dr++) begin
				for (dc = -1; dc <= 1; dc++) begin
					rr = int'(emit_row) + dr;
					cc = int'(emit_col) + dc;
					if (dr == 0 && dc == 0)
						continue;
					// off-frame neighbors are rock
					if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) begin
						live_nb++;
					end else begin
						off = dr * int'(w) + dc;
						idx = int'(center) + int'(HIST_LEN) + off;
						live_nb += hist_cells[idx % HIST_LEN];
					end
				end
			end
			if (cur)
				nxt = (live_nb >= cfg_survive);
			else
				nxt = (live_nb > cfg_birth);
			last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
			r.new_cell  = nxt;
			r.col       = emit_col[cas_pkg::COL_W-1:0];
			r.row       = emit_row[cas_pkg::ROW_W-1:0];
			r.frame_end = last;
			next_gen_q.push_back(r);
			if (last) begin
				// frame done: every position restarts
				feed_col = 0;
				feed_row = 0;
				emit_col = 0;
				emit_row = 0;
				hist_wr  = 0;
				return;
			end
			if (emit_col + 1 >= w) begin
				emit_col = 0;
				if (emit_row < 32'hFFFF)
					emit_row++;
			end else begin
				emit_col++;
			end
		end
		hist_wr = (hist_wr + 1) % HIST_LEN;
		if (feed_col + 1 >= w) begin
			feed_col = 0;
			if (feed_row < 32'h1FFFF)
				feed_row++;
		end else begin
			feed_col++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		cave_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (next_gen_q.size() == 0) begin
				$display("%0t: unexpected result transaction: new_cell=%0b col=%0d row=%0d end=%0b",
					$time, results_if.new_cell, results_if.col, results_if.row,
					results_if.frame_end);
				fail_count++;
			end else begin
				want = next_gen_q.pop_front();
				if (results_if.new_cell !== want.new_cell) begin
					$display("%0t: new_cell mismatch at (%0d,%0d): expected %0b, actual %0b",
						$time, want.row, want.col, want.new_cell, results_if.new_cell);
					fail_count++;
				end
				if (results_if.col !== want.col) begin
					$display("%0t: col mismatch: expected %0d, actual %0d",
						$time, want.col, results_if.col);
					fail_count++;
				end
				if (results_if.row !== want.row) begin
					$display("%0t: row mismatch: expected %0d, actual %0d",
						$time, want.row, results_if.row);
					fail_count++;
				end
				if (results_if.frame_end !== want.frame_end) begin
					$display("%0t: frame_end mismatch at (%0d,%0d): expected %0b, actual %0b",
						$time, want.row, want.col, want.frame_end, results_if.frame_end);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Present one cell and hold it until the transaction completes. valid stays high on
	// return so back-to-back cells keep a single NBA per signal per time step.
	task automatic send_cell(input bit cell_in, input bit drain);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cells_if.valid <= 1'b0;
			@(posedge clk);
		end
		cells_if.valid    <= 1'b1;
		cells_if.cell_req <= cell_in;
		cells_if.filler   <= drain;
		@(posedge clk);
		while (!cells_if.ready)
			@(posedge clk);
		predict_next_gen(cell_in, drain);
	endtask

	// Drop valid, let every predicted result come back, then give the pipeline time to
	// finish items that produce nothing before a register write.
	task automatic wait_idle();
		cells_if.valid <= 1'b0;
		while (next_gen_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Register write; upper data bits beyond the register width carry junk.
	// cfg_we is left high: the caller lowers it after the last write.
	task automatic write_reg(input cas_pkg::cfg_reg_t idx, input int unsigned value);
		logic [cas_pkg::CFG_DATA_W-1:0] data;
		int                             fw;
		case (idx)
			cas_pkg::REG_FRAME_WIDTH:  fw = cas_pkg::WID_W;
			cas_pkg::REG_FRAME_HEIGHT: fw = cas_pkg::HGT_W;
			default:                   fw = cas_pkg::LIM_W;
		endcase
		data = (cas_pkg::CFG_DATA_W'($urandom) << fw) | cas_pkg::CFG_DATA_W'(value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			cas_pkg::REG_FRAME_WIDTH:   cfg_width   = data[cas_pkg::WID_W-1:0];
			cas_pkg::REG_FRAME_HEIGHT:  cfg_height  = data[cas_pkg::HGT_W-1:0];
			cas_pkg::REG_SURVIVE_LIMIT: cfg_survive = data[cas_pkg::LIM_W-1:0];
			cas_pkg::REG_BIRTH_LIMIT:   cfg_birth   = data[cas_pkg::LIM_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input int unsigned w, h, s, b);
		write_reg(cas_pkg::REG_FRAME_WIDTH, w);
		write_reg(cas_pkg::REG_FRAME_HEIGHT, h);
		write_reg(cas_pkg::REG_SURVIVE_LIMIT, s);
		write_reg(cas_pkg::REG_BIRTH_LIMIT, b);
		cfg_we <= 1'b0;
	endtask

	// Full frame: width*height cells, then width+1 drain items. hole_pct puts fillers
	// inside the frame; junk_drain sends some drain items as plain cells.
	task automatic stream_frame(input int density, input int hole_pct, input bit junk_drain);
		int unsigned n_cells, n_drain, i;
		n_cells = eff_width() * eff_height();
		n_drain = eff_width() + 1;
		for (i = 0; i < n_cells; i++)
			send_cell($urandom_range(0, 99) < density, $urandom_range(0, 99) < hole_pct);
		for (i = 0; i < n_drain; i++) begin
			if (junk_drain && $urandom_range(0, 1))
				send_cell($urandom_range(0, 1), 1'b0);
			else
				send_cell($urandom_range(0, 1), 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Width and limits left at their reset values (64 wide, 4/4); two rows only.
	task automatic test_reset_config();
		write_reg(cas_pkg::REG_FRAME_HEIGHT, 2);
		cfg_we <= 1'b0;
		stream_frame(50, 0, 1'b0);
		wait_idle();
	endtask

	// Hand-built 3x2 frame: filler inside the frame and a plain cell among the drain.
	task automatic test_small_frame();
		program_regs(3, 2, 4, 4);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);  // filler in the frame: dead cell
		send_cell(1'b0, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b1, 1'b1);
		send_cell(1'b1, 1'b0);  // cell past the frame acts as filler
		send_cell(1'b0, 1'b1);
		wait_idle();
	endtask

	// Width and height of zero act as 1; survive 9 kills the border-only cell,
	// birth 8 blocks every birth. Two frames back to back.
	task automatic test_clamped_size();
		program_regs(0, 0, 9, 8);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b0, 1'b0);
		send_cell(1'b1, 1'b1);
		send_cell(1'b1, 1'b0);
		wait_idle();
	endtask

	// Limit extremes: all-ones limits, then thresholds right at the count.
	task automatic test_limit_extremes();
		program_regs(1, 1, 15, 15);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b0, 1'b1);
		wait_idle();
		// 2x1: each cell sees 7 border neighbors plus the other cell
		program_regs(2, 1, 8, 7);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b1, 1'b1);
		send_cell(1'b0, 1'b1);
		wait_idle();
	endtask

	// Tall frame: one column, the line buffer read and written at the same entry.
	task automatic test_tall_frame();
		program_regs(1, 120, $urandom_range(5, 8), $urandom_range(5, 7));
		stream_frame(50, 2, 1'b1);
		wait_idle();
	endtask

	// Wider frame over several rows: line buffer reused across rows.
	task automatic test_wide_frames();
		program_regs(96, 3, 3, 5);
		stream_frame(45, 3, 1'b1);
		wait_idle();
	endtask

	// Random frames under one idling mode; mostly small sizes, sometimes wider,
	// occasionally zero sizes and limits anywhere in their 4-bit range.
	task automatic test_random_frames(input int idle_pct, input int stall, input int n_items);
		int unsigned w, h, s, b, sent;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				wait_idle();
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
				h = $urandom_range(1, 8);
				if ($urandom_range(0, 19) == 0)
					w = 0;
				if ($urandom_range(0, 19) == 0)
					h = 0;
				s = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 15) : $urandom_range(2, 6);
				b = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 15) : $urandom_range(2, 6);
				program_regs(w, h, s, b);
			end
			// otherwise the next frame follows right after frame_end
			sent += eff_width() * eff_height() + eff_width() + 1;
			stream_frame($urandom_range(0, 100), $urandom_range(0, 1) ? 0 : 8,
				$urandom_range(0, 3) == 0);
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = cas_pkg::REG_FRAME_WIDTH;
		cfg_wdata         = '0;
		cells_if.valid    = 1'b0;
		cells_if.cell_req = 1'b0;
		cells_if.filler   = 1'b0;
		results_if.ready  = 1'b0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		fail_count        = 0;
		cfg_width         = cas_pkg::WIDTH_RST;
		cfg_height        = cas_pkg::HEIGHT_RST;
		cfg_survive       = cas_pkg::SURVIVE_RST;
		cfg_birth         = cas_pkg::BIRTH_RST;
		hist_wr           = 0;
		feed_col          = 0;
		feed_row          = 0;
		emit_col          = 0;
		emit_row          = 0;
		foreach (hist_cells[i])
			hist_cells[i] = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_small_frame();
		test_clamped_size();
		test_limit_extremes();
		test_tall_frame();
		send_idle_pct = 20;
		stall_pct     = 20;
		test_wide_frames();
		test_random_frames(0, 0, 270);
		test_random_frames(47, 0, 270);
		test_random_frames(0, 47, 270);
		test_random_frames(12, 12, 270);

		// wait_idle above already saw the queue empty and let the pipeline settle
		if (fail_count == 0)
			$display("cave_automaton_step_unit_tb: PASS");
		else
			$display("cave_automaton_step_unit_tb: FAIL");
		$finish;
	end

endmodule
